/* rtl/byte_ring_fifo_delimiter_scan_assert.svh */
// Assertion macros shared by the byte ring FIFO RTL
`ifndef BYTE_RING_FIFO_DELIMITER_SCAN_ASSERT_SVH
`define BYTE_RING_FIFO_DELIMITER_SCAN_ASSERT_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset
`define BRFDS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("brfds assertion failed");
// Check a property on every clock edge, reset included
`define BRFDS_ASSERT_NR(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("brfds assertion failed");
`else
`define BRFDS_ASSERT(label, prop)
`define BRFDS_ASSERT_NR(label, prop)
`endif
`endif

/* rtl/brfds_pkg.sv */
// Types, constants and helper functions of the byte ring FIFO
package brfds_pkg;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = PTR_W;

  localparam logic [7:0] DELIM_RESET = 8'd10;

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_SCAN = 2'd2,
    ACT_NOP  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ES_FOUND     = 2'd0,
    ES_REMAINDER = 2'd1,
    ES_NONE      = 2'd2
  } elem_status_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_code_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [7:0]   pop_byte;
    logic [7:0]   element_length;
    elem_status_e element_status;
    err_code_e    error_code;
  } result_t;

  // Advance a slot index around the ring
  function automatic ptr_t next_slot(input ptr_t p);
    ptr_t n;
    if (p == PTR_W'(DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  // Bytes held between read and write slots
  function automatic cnt_t used_of(input ptr_t rp, input ptr_t wp);
    cnt_t u;
    if (wp >= rp) begin
      u = CNT_W'(wp - rp);
    end else begin
      u = CNT_W'(32'(DEPTH) - 32'(rp) + 32'(wp));
    end
    return u;
  endfunction

  // Clamp a count to one byte
  function automatic logic [7:0] sat8(input cnt_t v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'd255) ? 8'hFF : w[7:0];
  endfunction

endpackage

/* rtl/brfds_ram.sv */
// Single-port-write, registered-read RAM holding the ring bytes
module brfds_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered output
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/byte_ring_fifo_delimiter_scan.sv */
// Top level of the byte ring FIFO with delimiter scan
//
//  Channel   Dir  Handshake                   Payload
//  s_axis    in   s_axis_tvalid/tready        tdata push_byte, tuser action, tlast input_ended
//  m_axis    out  m_axis_tvalid/tready        tdata bytes/counts, tuser status/error
//  cfg       in   cfg_valid_i/cfg_ready_o     cfg_data_i delimiter byte
//
// Push and no-op go from idle straight to the emit step; a pop passes through the
// pop state for its RAM read (straight to emit on an empty FIFO), and a scan walks
// the stored bytes one per cycle from the single RAM read port. A new transaction is taken
// while the previous result waits in the output register; the emit step
// stalls until that register is free. Reset clears the pointers and returns
// the delimiter to its reset value; the RAM is not cleared.
`include "byte_ring_fifo_delimiter_scan_assert.svh"

module byte_ring_fifo_delimiter_scan (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] push_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  input  logic        s_axis_tlast,   // input_ended
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] pop_byte, [15:8] element_length, [23:16] used_count, [31:24] free_count
  output logic [31:0] m_axis_tdata,
  output logic [3:0]  m_axis_tuser,   // [1:0] element_status, [3:2] error_code
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  brfds_pkg::state_e  state_q, state_d;
  brfds_pkg::ptr_t    rd_ptr_q, rd_ptr_d;
  brfds_pkg::ptr_t    wr_ptr_q, wr_ptr_d;
  brfds_pkg::ptr_t    scan_ptr_q, scan_ptr_d;
  brfds_pkg::cnt_t    cnt_q, cnt_d;
  brfds_pkg::result_t res_q, res_d;
  logic               ended_q, ended_d;
  logic [7:0]         delim_q;
  logic               m_valid_q;
  logic [31:0]        m_data_q;
  logic [3:0]         m_user_q;

  logic               s_fire;
  logic               out_free;
  logic               load_out;
  brfds_pkg::cnt_t    used_w;
  brfds_pkg::cnt_t    free_w;
  logic               full_w;
  logic               empty_w;
  brfds_pkg::cnt_t    cnt_inc;
  brfds_pkg::ptr_t    scan_nxt;
  logic               scan_hit;
  logic               scan_end;
  brfds_pkg::action_e action_w;

  logic               ram_we;
  logic               ram_re;
  brfds_pkg::ptr_t    ram_raddr;
  logic [7:0]         ram_rdata;

  // Byte storage
  brfds_ram #(
    .DATA_W(8),
    .DEPTH (brfds_pkg::DEPTH),
    .ADDR_W(brfds_pkg::PTR_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_ptr_q),
    .wdata_i(s_axis_tdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Handshakes and occupancy
  assign s_axis_tready = (state_q == brfds_pkg::ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign action_w      = brfds_pkg::action_e'(s_axis_tuser);
  assign used_w        = brfds_pkg::used_of(rd_ptr_q, wr_ptr_q);
  assign free_w        = brfds_pkg::CNT_W'(brfds_pkg::DEPTH - 1) - used_w;
  assign full_w        = (used_w == brfds_pkg::CNT_W'(brfds_pkg::DEPTH - 1));
  assign empty_w       = (rd_ptr_q == wr_ptr_q);

  // Scan step: byte at scan_ptr_q arrives on the read port this cycle
  assign cnt_inc  = cnt_q + 1'b1;
  assign scan_nxt = brfds_pkg::next_slot(scan_ptr_q);
  assign scan_hit = (ram_rdata == delim_q);
  assign scan_end = (scan_nxt == wr_ptr_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      brfds_pkg::ST_IDLE: begin
        if (s_fire) begin
          case (action_w)
            brfds_pkg::ACT_POP:  state_d = empty_w ? brfds_pkg::ST_EMIT : brfds_pkg::ST_POP;
            brfds_pkg::ACT_SCAN: state_d = empty_w ? brfds_pkg::ST_EMIT : brfds_pkg::ST_SCAN;
            default:             state_d = brfds_pkg::ST_EMIT;
          endcase
        end
      end
      brfds_pkg::ST_POP: state_d = brfds_pkg::ST_EMIT;
      brfds_pkg::ST_SCAN: begin
        if (scan_hit || scan_end) begin
          state_d = brfds_pkg::ST_EMIT;
        end
      end
      brfds_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = brfds_pkg::ST_IDLE;
        end
      end
      default: state_d = brfds_pkg::ST_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = rd_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    scan_ptr_d = scan_ptr_q;
    cnt_d      = cnt_q;
    res_d      = res_q;
    ended_d    = ended_q;
    load_out   = 1'b0;
    case (state_q)
      brfds_pkg::ST_IDLE: begin
        if (s_fire) begin
          ended_d              = s_axis_tlast;
          res_d.pop_byte       = 8'd0;
          res_d.element_length = 8'd0;
          res_d.element_status = brfds_pkg::ES_NONE;
          res_d.error_code     = brfds_pkg::ERR_OK;
          case (action_w)
            brfds_pkg::ACT_PUSH: begin
              if (full_w) begin
                res_d.error_code = brfds_pkg::ERR_FULL;
              end else begin
                ram_we   = 1'b1;
                wr_ptr_d = brfds_pkg::next_slot(wr_ptr_q);
              end
            end
            brfds_pkg::ACT_POP: begin
              if (empty_w) begin
                res_d.error_code = brfds_pkg::ERR_EMPTY;
              end else begin
                ram_re = 1'b1;
              end
            end
            brfds_pkg::ACT_SCAN: begin
              if (!empty_w) begin
                ram_re     = 1'b1;
                scan_ptr_d = rd_ptr_q;
                cnt_d      = '0;
              end
            end
            default: ;
          endcase
        end
      end
      brfds_pkg::ST_POP: begin
        res_d.pop_byte = ram_rdata;
        rd_ptr_d       = brfds_pkg::next_slot(rd_ptr_q);
      end
      brfds_pkg::ST_SCAN: begin
        if (scan_hit) begin
          res_d.element_length = brfds_pkg::sat8(cnt_inc);
          res_d.element_status = brfds_pkg::ES_FOUND;
        end else if (scan_end) begin
          if (ended_q) begin
            res_d.element_length = brfds_pkg::sat8(cnt_inc);
            res_d.element_status = brfds_pkg::ES_REMAINDER;
          end
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = scan_nxt;
          scan_ptr_d = scan_nxt;
          cnt_d      = cnt_inc;
        end
      end
      brfds_pkg::ST_EMIT: load_out = out_free;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= brfds_pkg::ST_IDLE;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      delim_q  <= brfds_pkg::DELIM_RESET;
    end else begin
      state_q  <= state_d;
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      if (cfg_valid_i && cfg_ready_o) begin
        delim_q <= cfg_data_i;
      end
    end
  end

  // Working registers of the current transaction
  always_ff @(posedge clk_i) begin
    scan_ptr_q <= scan_ptr_d;
    cnt_q      <= cnt_d;
    res_q      <= res_d;
    ended_q    <= ended_d;
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // Output payload, counts taken after the pointer update
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= {brfds_pkg::sat8(free_w), brfds_pkg::sat8(used_w),
                   res_q.element_length, res_q.pop_byte};
      m_user_q <= {res_q.error_code, res_q.element_status};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // The ring never holds more than DEPTH-1 bytes
  `BRFDS_ASSERT(a_used_bound, used_w <= brfds_pkg::CNT_W'(brfds_pkg::DEPTH - 1))
  // The write slot moves only on an accepted push
  `BRFDS_ASSERT(a_wr_ptr_push, !(s_fire && action_w == brfds_pkg::ACT_PUSH) |=> $stable(wr_ptr_q))
  // The read slot moves only after a pop read
  `BRFDS_ASSERT(a_rd_ptr_pop, (state_q != brfds_pkg::ST_POP) |=> $stable(rd_ptr_q))
  // A scan never reads the free region
  `BRFDS_ASSERT(a_scan_in_ring, (state_q == brfds_pkg::ST_SCAN) |-> (scan_ptr_q != wr_ptr_q))
  // The output register is loaded only when free
  `BRFDS_ASSERT_NR(a_load_free, !load_out || !m_valid_q || m_axis_tready)

endmodule

/* bench/fifo_scan_monitor.sv */
// Channel monitor with a prediction of the byte ring FIFO and its delimiter scan
module fifo_scan_monitor
  import brfds_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] push_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  input  logic        s_axis_tlast,   // input_ended
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] pop_byte, [15:8] element_length, [23:16] used_count, [31:24] free_count
  input  logic [31:0] m_axis_tdata,
  input  logic [3:0]  m_axis_tuser,   // [1:0] element_status, [3:2] error_code
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 30;

  typedef struct {
    logic [7:0]   pop_byte;
    logic [7:0]   element_length;
    elem_status_e status;
    logic [7:0]   used;
    logic [7:0]   free;
    err_code_e    err;
  } fifo_result_t;

  // Predicted FIFO contents, pointers and delimiter
  logic [7:0]   ring_mem [DEPTH];
  int           rd_slot;
  int           wr_slot;
  logic [7:0]   delim;
  fifo_result_t expected_results [$];

  // Run statistics for the closing summary
  int n_by_action [4];
  int n_results;
  int n_full_drops;
  int n_empty_pops;
  int n_found;
  int n_remainder;
  int peak_level;

  function automatic logic [7:0] clamp_byte(input int v);
    return (v > 255) ? 8'hFF : v[7:0];
  endfunction

  function automatic int fill_level();
    return (wr_slot + int'(DEPTH) - rd_slot) % int'(DEPTH);
  endfunction

  // Apply one input transaction to the predicted state and return its result
  function automatic fifo_result_t predict_fifo_item(input action_e act,
                                                     input logic [7:0] data,
                                                     input logic ended);
    fifo_result_t r;
    int held;
    int idx;
    int walked;
    bit hit;
    held = fill_level();
    r.pop_byte = '0;
    r.element_length = '0;
    r.status = ES_NONE;
    r.err = ERR_OK;
    n_by_action[int'(act)]++;
    case (act)
      ACT_PUSH: begin
        if (held >= int'(DEPTH) - 1) begin
          r.err = ERR_FULL;
          n_full_drops++;
        end else begin
          ring_mem[wr_slot] = data;
          wr_slot = (wr_slot + 1) % int'(DEPTH);
        end
      end
      ACT_POP: begin
        if (held == 0) begin
          r.err = ERR_EMPTY;
          n_empty_pops++;
        end else begin
          r.pop_byte = ring_mem[rd_slot];
          rd_slot = (rd_slot + 1) % int'(DEPTH);
        end
      end
      ACT_SCAN: begin
        // Walk from the oldest byte up to and including the first delimiter
        idx = rd_slot;
        walked = 0;
        hit = 1'b0;
        while (idx != wr_slot && walked < int'(DEPTH) && !hit) begin
          walked++;
          if (ring_mem[idx] == delim) begin
            hit = 1'b1;
          end else begin
            idx = (idx + 1) % int'(DEPTH);
          end
        end
        if (hit) begin
          r.element_length = clamp_byte(walked);
          r.status = ES_FOUND;
          n_found++;
        end else if (ended && walked > 0) begin
          r.element_length = clamp_byte(walked);
          r.status = ES_REMAINDER;
          n_remainder++;
        end
      end
      default: begin
      end
    endcase
    held = fill_level();
    if (held > peak_level) begin
      peak_level = held;
    end
    r.used = clamp_byte(held);
    r.free = clamp_byte(int'(DEPTH) - 1 - held);
    return r;
  endfunction

  // Print one mismatch line (up to a cap) and count it
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count_o < PRINT_CAP) begin
      $display("[%0t] ERROR %s at result %0d: got 0x%0h, expected 0x%0h",
               $realtime, what, n_results, got, want);
    end
    fail_count_o++;
  endtask

  // Track configuration, compare results, predict new transactions
  always @(posedge clk_i or negedge rst_ni) begin
    fifo_result_t want;
    if (!rst_ni) begin
      rd_slot = 0;
      wr_slot = 0;
      delim = DELIM_RESET;
      expected_results.delete();
      pending_o = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        delim = cfg_data_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", m_axis_tdata, '0);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[7:0] !== want.pop_byte)
            report_mismatch("pop_byte", m_axis_tdata[7:0], want.pop_byte);
          if (m_axis_tdata[15:8] !== want.element_length)
            report_mismatch("element_length", m_axis_tdata[15:8], want.element_length);
          if (m_axis_tdata[23:16] !== want.used)
            report_mismatch("used_count", m_axis_tdata[23:16], want.used);
          if (m_axis_tdata[31:24] !== want.free)
            report_mismatch("free_count", m_axis_tdata[31:24], want.free);
          if (m_axis_tuser[1:0] !== want.status)
            report_mismatch("element_status", m_axis_tuser[1:0], want.status);
          if (m_axis_tuser[3:2] !== want.err)
            report_mismatch("error_code", m_axis_tuser[3:2], want.err);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(predict_fifo_item(action_e'(s_axis_tuser),
                                                     s_axis_tdata, s_axis_tlast));
      end
      pending_o = expected_results.size();
    end
  end

endmodule

/* bench/testbench.sv */
// Top of the byte ring FIFO bench: clock, reset, stimulus, watchdog and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import brfds_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;

  int         fail_count;
  int         pending;
  int         idle_pct;
  int         stall_pct;
  logic       hold_req;
  logic       hold_done;
  logic [7:0] cur_delim;
  int         n_delim_writes;
  int         quiet_cycles;

  always #6 clk_i = ~clk_i;

  byte_ring_fifo_delimiter_scan i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  fifo_scan_monitor i_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Drive the result-side ready: random stalls, or one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  // End the run if no transaction moves on any channel for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, pending);
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one input transaction, with random idle cycles ahead of it
  task automatic send_item(input action_e act, input logic [7:0] data, input logic ended);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= data;
    s_axis_tlast  <= ended;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold the sender until every expected result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_delim(input logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_delim = value;
    n_delim_writes++;
  endtask

  // Random transactions with the given push/pop/scan weights; no-op takes the rest
  task automatic run_phase(input int items, input int idle, input int stall,
                           input int push_w, input int pop_w, input int scan_w,
                           input logic [7:0] new_delim, input bit long_hold);
    int r;
    action_e act;
    logic [7:0] data;
    drain();
    write_delim(new_delim);
    idle_pct = idle;
    stall_pct = stall;
    if (long_hold) begin
      hold_req = 1'b1;
    end
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(99);
      if (r < push_w) begin
        act = ACT_PUSH;
      end else if (r < push_w + pop_w) begin
        act = ACT_POP;
      end else if (r < push_w + pop_w + scan_w) begin
        act = ACT_SCAN;
      end else begin
        act = ACT_NOP;
      end
      // bias the byte stream towards the delimiter so scans find elements
      data = ($urandom_range(5) == 0) ? cur_delim : 8'($urandom);
      send_item(act, data, 1'($urandom));
      if (k % 100 == 99) begin
        drain();
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ACT_PUSH;
    s_axis_tlast = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    cur_delim = DELIM_RESET;
    n_delim_writes = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty cases, no-op, remainder, found element, reset delimiter
    send_item(ACT_POP,  8'h00, 1'b0);
    send_item(ACT_SCAN, 8'h00, 1'b1);
    send_item(ACT_SCAN, 8'h00, 1'b0);
    send_item(ACT_NOP,  8'hFF, 1'b1);
    send_item(ACT_PUSH, 8'h00, 1'b0);
    send_item(ACT_PUSH, 8'hFF, 1'b1);
    send_item(ACT_SCAN, 8'h00, 1'b0);
    send_item(ACT_SCAN, 8'h00, 1'b1);
    send_item(ACT_PUSH, DELIM_RESET, 1'b0);
    send_item(ACT_PUSH, 8'h55, 1'b0);
    send_item(ACT_SCAN, 8'h00, 1'b0);
    send_item(ACT_PUSH, 8'hAA, 1'b0);
    send_item(ACT_POP,  8'h00, 1'b0);
    send_item(ACT_SCAN, 8'h00, 1'b1);
    send_item(ACT_POP,  8'h00, 1'b0);
    send_item(ACT_POP,  8'h00, 1'b0);
    send_item(ACT_SCAN, 8'h00, 1'b1);
    send_item(ACT_POP,  8'h00, 1'b0);
    send_item(ACT_POP,  8'h00, 1'b0);
    send_item(ACT_POP,  8'h00, 1'b0);
    send_item(ACT_PUSH, DELIM_RESET, 1'b0);
    send_item(ACT_SCAN, 8'h00, 1'b0);
    send_item(ACT_POP,  8'h00, 1'b0);

    // Fill past full, drain past empty, then mixed traffic under back-pressure
    run_phase(400, 0,  0,  85, 3,  10, 8'h00, 1'b0);
    run_phase(400, 88, 0,  5,  82, 10, 8'hFF, 1'b0);
    run_phase(200, 0,  88, 45, 40, 12, 8'($urandom), 1'b1);
    run_phase(200, 31, 31, 45, 40, 12, DELIM_RESET, 1'b0);

    drain();
    stall_pct = 0;
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("Covered %0d results: %0d push, %0d pop, %0d scan, %0d no-op, %0d delimiters",
             i_monitor.n_results, i_monitor.n_by_action[ACT_PUSH],
             i_monitor.n_by_action[ACT_POP], i_monitor.n_by_action[ACT_SCAN],
             i_monitor.n_by_action[ACT_NOP], n_delim_writes + 1);
    $display("Full drops %0d, empty pops %0d, elements found %0d, remainders %0d, peak %0d",
             i_monitor.n_full_drops, i_monitor.n_empty_pops, i_monitor.n_found,
             i_monitor.n_remainder, i_monitor.peak_level);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* byte_ring_fifo_delimiter_scan.f */
+incdir+rtl
rtl/brfds_pkg.sv
rtl/brfds_ram.sv
rtl/byte_ring_fifo_delimiter_scan.sv
bench/fifo_scan_monitor.sv
bench/testbench.sv
